// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the key event queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the cycle after its antecedent, outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/kes_pkg.sv =====
// ----------------------------------------------------------------------------
// Key event queue package
// Sizes, result codes and shared types of the key event ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kes_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int CELLS = QUEUE_SLOTS - 1;
  localparam int CNT_W = $clog2(QUEUE_SLOTS);

  localparam logic [15:0] TIMER_STATUS_RESET = 16'h1013;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_DEQUEUE = 1'b1;

  localparam logic [1:0] RES_DONE      = 2'd0;
  localparam logic [1:0] RES_FULL      = 2'd1;
  localparam logic [1:0] RES_DUP_TIMER = 2'd2;
  localparam logic [1:0] RES_EMPTY     = 2'd3;

  typedef struct packed {
    logic [15:0] status;
    logic [15:0] code;
  } kes_word_t;

  typedef struct packed {
    logic load;
    logic shift;
  } kes_cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/key_event_ring_queue.sv =====
// ----------------------------------------------------------------------------
// Key event ring queue
// FIFO of key events built as a chain of cells, with the oldest event in
// cell zero, and at most one pending timer event.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata code, status; tuser func
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata code, status; tuser result
// cfg       in   cfg_valid/cfg_ready           cfg_data timer status
//
// Every word gives one result word. A dequeue, an enqueue refused as full and
// an enqueue of a non-timer status commit once the output register is free;
// any other enqueue of the timer status, done or refused as a duplicate, also
// waits for the pending flag to ripple through the cells.
// A result waits in the output register while m_axis_tready is low, and the
// next word is taken once that result is in the register.
// Reset is synchronous; afterwards the queue is empty and ready at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module key_event_ring_queue (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [31:0] s_axis_tdata,   // key_code, key_status
  input  wire [0:0]  s_axis_tuser,   // func
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_code, out_status
  output logic [1:0] m_axis_tuser,   // result_status
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [15:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  localparam int CELLS = kes_pkg::CELLS;
  localparam int CNT_W = kes_pkg::CNT_W;

  logic                   state;
  logic                   func_q;
  kes_pkg::kes_word_t     item;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       cycles;
  logic [15:0]            timer_status;

  kes_pkg::kes_cell_ctl_t ctl       [CELLS];
  kes_pkg::kes_word_t     cell_word [CELLS];
  logic [CELLS-1:0]       cell_valid;
  logic [CELLS-1:0]       cell_carry;

  logic                   is_full;
  logic                   is_empty;
  logic                   is_timer;
  logic                   need_scan;
  logic                   out_free;
  logic                   commit;
  logic                   do_load;
  logic                   do_shift;
  logic [1:0]             res;

  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign cfg_ready     = !rst;

  assign is_full   = (count == CNT_W'(CELLS));
  assign is_empty  = (count == '0);
  assign is_timer  = (item.status == timer_status);
  assign need_scan = (func_q == kes_pkg::FUNC_ENQUEUE) && !is_full && is_timer;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign commit    = (state == ST_WORK) && out_free
                     && (!need_scan || (cycles == CNT_W'(CELLS)));

  always_comb begin
    res      = kes_pkg::RES_DONE;
    do_load  = 1'b0;
    do_shift = 1'b0;
    if (func_q == kes_pkg::FUNC_ENQUEUE) begin
      if (is_full) begin
        res = kes_pkg::RES_FULL;
      end else if (is_timer && cell_carry[0]) begin
        res = kes_pkg::RES_DUP_TIMER;
      end else begin
        do_load = commit;
      end
    end else begin
      if (is_empty) begin
        res = kes_pkg::RES_EMPTY;
      end else begin
        do_shift = commit;
      end
    end
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    kes_pkg::kes_word_t nbr_word;
    logic               nbr_valid;
    logic               nbr_carry;

    if (i == CELLS - 1) begin : g_tail
      assign nbr_word  = '0;
      assign nbr_valid = 1'b0;
      assign nbr_carry = 1'b0;
    end else begin : g_body
      assign nbr_word  = cell_word[i+1];
      assign nbr_valid = cell_valid[i+1];
      assign nbr_carry = cell_carry[i+1];
    end

    assign ctl[i].load  = do_load && (count == CNT_W'(i));
    assign ctl[i].shift = do_shift;

    kes_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl[i]),
      .timer_status (timer_status),
      .load_word    (item),
      .nbr_word     (nbr_word),
      .nbr_valid    (nbr_valid),
      .nbr_carry    (nbr_carry),
      .word         (cell_word[i]),
      .valid        (cell_valid[i]),
      .carry        (cell_carry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tuser[0];
      item   <= s_axis_tdata;
    end
    if (commit) begin
      m_axis_tuser <= res;
      m_axis_tdata <= do_shift ? cell_word[0] : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      cycles        <= '0;
      m_axis_tvalid <= 1'b0;
      timer_status  <= kes_pkg::TIMER_STATUS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timer_status <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state  <= ST_WORK;
            cycles <= '0;
          end
        end
        ST_WORK: begin
          if (cycles != CNT_W'(CELLS)) begin
            cycles <= cycles + CNT_W'(1);
          end
          if (commit) begin
            state         <= ST_IDLE;
            m_axis_tvalid <= 1'b1;
            if (do_load) begin
              count <= count + CNT_W'(1);
            end else if (do_shift) begin
              count <= count - CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_count_bound, count <= CNT_W'(CELLS), "queue count beyond capacity")
  `ASSERT_CLK(a_valid_count, $countones(cell_valid) == int'(count),
              "cell valid bits disagree with count")
  `ASSERT_NEXT(a_commit_result, commit, m_axis_tvalid && (state == ST_IDLE),
               "commit did not present a result")
  `ASSERT_NEXT(a_enq_grows, commit && do_load, count == $past(count) + CNT_W'(1),
               "enqueue did not grow the queue")

endmodule

`default_nettype wire

// ===== src/kes_cell.sv =====
// ----------------------------------------------------------------------------
// Key event queue cell
// One queue slot: holds an event, shifts toward the head on a dequeue and
// passes a timer-pending flag toward the head one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kes_cell (
  input  wire                         clk,
  input  wire                         rst,
  input  wire kes_pkg::kes_cell_ctl_t ctl,
  input  wire [15:0]                  timer_status,
  input  wire kes_pkg::kes_word_t     load_word,
  input  wire kes_pkg::kes_word_t     nbr_word,
  input  wire                         nbr_valid,
  input  wire                         nbr_carry,
  output kes_pkg::kes_word_t          word,
  output logic                        valid,
  output logic                        carry
);

  logic hit;

  assign hit = valid && (word.status == timer_status);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= load_word;
    end else if (ctl.shift) begin
      word <= nbr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      carry <= 1'b0;
    end else begin
      if (ctl.load) begin
        valid <= 1'b1;
      end else if (ctl.shift) begin
        valid <= nbr_valid;
      end
      carry <= hit || nbr_carry;
    end
  end

endmodule

`default_nettype wire
